/* design/tmis_pkg.sv */
// ----------------------------------------------------------------------------
// tmis_pkg: shared definitions for the tape machine
// Depths, widths, command and instruction codes, payload and memory port types.
// ----------------------------------------------------------------------------
package tmis_pkg;

  // The three memory depths must be powers of two. Addresses then wrap by
  // truncation.
  localparam int PROG_DEPTH  = 8192;
  localparam int TAPE_DEPTH  = 8192;
  localparam int STACK_DEPTH = 1024;

  localparam int ADDR_W   = 13;
  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 2;
  localparam int PROG_AW  = $clog2(PROG_DEPTH);
  localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
  localparam int LEVEL_W  = PROG_AW + 1;

  // The clearing sweep covers the larger of the two byte memories.
  localparam int CLR_DEPTH = (PROG_DEPTH > TAPE_DEPTH) ? PROG_DEPTH : TAPE_DEPTH;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXEC    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [BYTE_W-1:0] OP_HALT  = 8'h00;
  localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] prog_addr;
    logic [BYTE_W-1:0] prog_byte;
    logic [BYTE_W-1:0] key_byte;
  } req_t;

  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              key_used;
    logic              halted;
    logic              bad_instruction;
    logic              stack_fault;
    logic [ADDR_W-1:0] program_counter;
    logic [ADDR_W-1:0] tape_position;
  } rsp_t;

  typedef struct packed {
    logic               we;
    logic [PROG_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [PROG_AW-1:0] raddr;
  } prog_port_t;

  typedef struct packed {
    logic               we;
    logic [TAPE_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [TAPE_AW-1:0] raddr;
  } tape_port_t;

  typedef struct packed {
    logic                we;
    logic [STACK_AW-1:0] waddr;
    logic [PROG_AW-1:0]  wdata;
    logic                re;
    logic [STACK_AW-1:0] raddr;
  } stack_port_t;

endpackage

/* design/tmis_req_if.sv */
// ----------------------------------------------------------------------------
// tmis_req_if: command channel
// Valid/ready channel that carries one command item per transfer.
// ----------------------------------------------------------------------------
interface tmis_req_if import tmis_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/tmis_rsp_if.sv */
// ----------------------------------------------------------------------------
// tmis_rsp_if: result channel
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
interface tmis_rsp_if import tmis_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/tape_machine_instruction_step.sv */
// ----------------------------------------------------------------------------
// tape_machine_instruction_step: eight-instruction tape machine
// Loads program bytes, executes one instruction per command, restarts.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                        Handshake
//   req      in   cmd, prog_addr, prog_byte, key_byte            valid/ready
//   rsp      out  out_valid, out_byte, key_used, halted,          valid/ready
//                 bad_instruction, stack_fault, program_counter,
//                 tape_position
//
// A load, an execute of a simple instruction, or an ignored command runs
// through the transfer cycle, which issues the memory reads or the
// program write, and then a step that executes and writes back. A taken
// ']' adds a step for the return stack read. A '[' on a zero cell scans
// the program memory one byte per cycle while the output register can
// take a result. A restart sweeps the data tape, one entry per cycle,
// before its result. After reset the same sweep clears both the program
// memory and the tape with req.ready low. Results wait in an output
// register; while it is full and not being drained, the sequencer holds
// its final step.
//
module tape_machine_instruction_step import tmis_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tmis_req_if.sink   req,
  tmis_rsp_if.source rsp
);

  prog_port_t         prog_p;
  tape_port_t         tape_p;
  stack_port_t        stack_p;
  logic [BYTE_W-1:0]  prog_rdata;
  logic [BYTE_W-1:0]  tape_rdata;
  logic [PROG_AW-1:0] stack_rdata;
  rsp_t               result;
  logic               result_load;
  logic               slot_free;
  logic               slot_full;
  rsp_t               slot_data;

  // Program memory: written by load commands and by the clearing sweep
  // after reset, read for instruction fetch and bracket scans.
  tmis_ram #(.WIDTH(BYTE_W), .DEPTH(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_p.we),
    .waddr (prog_p.waddr),
    .wdata (prog_p.wdata),
    .re    (prog_p.re),
    .raddr (prog_p.raddr),
    .rdata (prog_rdata)
  );

  // Data tape: read at fetch time, written back during execution.
  tmis_ram #(.WIDTH(BYTE_W), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_p.we),
    .waddr (tape_p.waddr),
    .wdata (tape_p.wdata),
    .re    (tape_p.re),
    .raddr (tape_p.raddr),
    .rdata (tape_rdata)
  );

  // Return stack of loop start addresses. Only entries below the current
  // depth are ever read, so it needs no clearing.
  tmis_ram #(.WIDTH(PROG_AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stack_p.we),
    .waddr (stack_p.waddr),
    .wdata (stack_p.wdata),
    .re    (stack_p.re),
    .raddr (stack_p.raddr),
    .rdata (stack_rdata)
  );

  tmis_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .prog_p      (prog_p),
    .prog_rdata  (prog_rdata),
    .tape_p      (tape_p),
    .tape_rdata  (tape_rdata),
    .stack_p     (stack_p),
    .stack_rdata (stack_rdata),
    .result      (result),
    .result_load (result_load),
    .slot_free   (slot_free)
  );

  // Output register. The slot can take a new result in the same cycle in
  // which the held one is transferred.
  assign slot_free = !slot_full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full <= 1'b0;
    end else if (result_load) begin
      slot_full <= 1'b1;
    end else if (rsp.ready) begin
      slot_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      slot_data <= result;
    end
  end

  assign rsp.valid = slot_full;
  assign rsp.data  = slot_data;

endmodule

/* design/tmis_ram.sv */
// ----------------------------------------------------------------------------
// tmis_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module tmis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/tmis_ctrl.sv */
// ----------------------------------------------------------------------------
// tmis_ctrl: instruction sequencer
// Holds the machine registers and drives the program, tape and stack memories.
// ----------------------------------------------------------------------------
module tmis_ctrl import tmis_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  tmis_req_if.sink           req,
  output prog_port_t         prog_p,
  input  logic [BYTE_W-1:0]  prog_rdata,
  output tape_port_t         tape_p,
  input  logic [BYTE_W-1:0]  tape_rdata,
  output stack_port_t        stack_p,
  input  logic [PROG_AW-1:0] stack_rdata,
  output rsp_t               result,
  output logic               result_load,
  input  logic               slot_free
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SKIP  = 3'd3;
  localparam logic [2:0] ST_POP   = 3'd4;
  localparam logic [2:0] ST_REPLY = 3'd5;

  logic [2:0]         state, state_next;
  logic               boot, boot_next;
  logic [CLR_AW-1:0]  clr_addr, clr_addr_next;
  logic [PROG_AW-1:0] pc, pc_next;
  logic [TAPE_AW-1:0] cp, cp_next;
  logic [DEPTH_W-1:0] depth, depth_next;
  logic               stopped, stopped_next;
  logic [BYTE_W-1:0]  key, key_next;
  logic [PROG_AW-1:0] scan_pos, scan_pos_next;
  logic [LEVEL_W-1:0] level, level_next;
  logic               accept;
  logic               scan_go_on;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    state_next    = state;
    boot_next     = boot;
    clr_addr_next = clr_addr;
    pc_next       = pc;
    cp_next       = cp;
    depth_next    = depth;
    stopped_next  = stopped;
    key_next      = key;
    scan_pos_next = scan_pos;
    level_next    = level;
    scan_go_on    = 1'b0;
    prog_p        = '0;
    tape_p        = '0;
    stack_p       = '0;
    result        = '0;
    result_load   = 1'b0;

    case (state)
      ST_CLEAR: begin
        tape_p.we    = ({1'b0, clr_addr} < (CLR_AW + 1)'(TAPE_DEPTH));
        tape_p.waddr = TAPE_AW'(clr_addr);
        prog_p.we    = boot && ({1'b0, clr_addr} < (CLR_AW + 1)'(PROG_DEPTH));
        prog_p.waddr = PROG_AW'(clr_addr);
        clr_addr_next = clr_addr + CLR_AW'(1);
        if (clr_addr == CLR_AW'(CLR_DEPTH - 1)) begin
          state_next = boot ? ST_IDLE : ST_REPLY;
          boot_next  = 1'b0;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          case (req.data.cmd)
            CMD_LOAD: begin
              prog_p.we    = 1'b1;
              prog_p.waddr = PROG_AW'(req.data.prog_addr);
              prog_p.wdata = req.data.prog_byte;
              state_next   = ST_REPLY;
            end
            CMD_RESTART: begin
              pc_next       = '0;
              cp_next       = '0;
              depth_next    = '0;
              stopped_next  = 1'b0;
              clr_addr_next = '0;
              state_next    = ST_CLEAR;
            end
            CMD_EXEC: begin
              if (stopped) begin
                state_next = ST_REPLY;
              end else begin
                prog_p.re    = 1'b1;
                prog_p.raddr = pc;
                tape_p.re    = 1'b1;
                tape_p.raddr = cp;
                key_next     = req.data.key_byte;
                state_next   = ST_EXEC;
              end
            end
            default: begin
              state_next = ST_REPLY;
            end
          endcase
        end
      end

      ST_EXEC: begin
        if (slot_free) begin
          pc_next     = pc + PROG_AW'(1);
          result_load = 1'b1;
          state_next  = ST_IDLE;
          case (prog_rdata)
            OP_RIGHT: cp_next = cp + TAPE_AW'(1);
            OP_LEFT:  cp_next = cp - TAPE_AW'(1);
            OP_INC: begin
              tape_p.we    = 1'b1;
              tape_p.waddr = cp;
              tape_p.wdata = tape_rdata + BYTE_W'(1);
            end
            OP_DEC: begin
              tape_p.we    = 1'b1;
              tape_p.waddr = cp;
              tape_p.wdata = tape_rdata - BYTE_W'(1);
            end
            OP_IN: begin
              tape_p.we       = 1'b1;
              tape_p.waddr    = cp;
              tape_p.wdata    = key;
              result.key_used = 1'b1;
            end
            OP_OUT: begin
              result.out_valid = 1'b1;
              result.out_byte  = tape_rdata;
            end
            OP_OPEN: begin
              if (tape_rdata == '0) begin
                if (pc == PROG_AW'(PROG_DEPTH - 1)) begin
                  pc_next = '0;
                end else begin
                  // Start the forward scan for the matching bracket.
                  prog_p.re     = 1'b1;
                  prog_p.raddr  = pc + PROG_AW'(1);
                  scan_pos_next = pc + PROG_AW'(1);
                  level_next    = LEVEL_W'(1);
                  pc_next       = pc;
                  result_load   = 1'b0;
                  state_next    = ST_SKIP;
                end
              end else if (depth == DEPTH_W'(STACK_DEPTH)) begin
                result.stack_fault = 1'b1;
              end else begin
                stack_p.we    = 1'b1;
                stack_p.waddr = STACK_AW'(depth);
                stack_p.wdata = pc;
                depth_next    = depth + DEPTH_W'(1);
              end
            end
            OP_CLOSE: begin
              if (depth == '0) begin
                result.stack_fault = 1'b1;
              end else if (tape_rdata != '0) begin
                stack_p.re    = 1'b1;
                stack_p.raddr = STACK_AW'(depth - DEPTH_W'(1));
                pc_next       = pc;
                result_load   = 1'b0;
                state_next    = ST_POP;
              end else begin
                depth_next = depth - DEPTH_W'(1);
              end
            end
            OP_HALT: begin
              stopped_next = 1'b1;
              pc_next      = pc;
            end
            default: begin
              result.bad_instruction = 1'b1;
            end
          endcase
        end
      end

      ST_SKIP: begin
        if (slot_free) begin
          if (prog_rdata == OP_HALT) begin
            // An unmatched bracket leaves the pointer on the zero byte.
            pc_next     = scan_pos;
            result_load = 1'b1;
            state_next  = ST_IDLE;
          end else if (prog_rdata == OP_CLOSE && level == LEVEL_W'(1)) begin
            pc_next     = scan_pos + PROG_AW'(1);
            result_load = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            scan_go_on = 1'b1;
            if (prog_rdata == OP_OPEN) begin
              level_next = level + LEVEL_W'(1);
            end else if (prog_rdata == OP_CLOSE) begin
              level_next = level - LEVEL_W'(1);
            end
          end
          if (scan_go_on) begin
            if (scan_pos == PROG_AW'(PROG_DEPTH - 1)) begin
              pc_next     = '0;
              result_load = 1'b1;
              state_next  = ST_IDLE;
            end else begin
              prog_p.re     = 1'b1;
              prog_p.raddr  = scan_pos + PROG_AW'(1);
              scan_pos_next = scan_pos + PROG_AW'(1);
            end
          end
        end
      end

      ST_POP: begin
        if (slot_free) begin
          pc_next     = stack_rdata + PROG_AW'(1);
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end

      ST_REPLY: begin
        if (slot_free) begin
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // The result always reports the registers as they stand after the step.
    result.halted          = stopped_next;
    result.program_counter = ADDR_W'(pc_next);
    result.tape_position   = ADDR_W'(cp_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      boot     <= 1'b1;
      clr_addr <= '0;
      pc       <= '0;
      cp       <= '0;
      depth    <= '0;
      stopped  <= 1'b0;
    end else begin
      state    <= state_next;
      boot     <= boot_next;
      clr_addr <= clr_addr_next;
      pc       <= pc_next;
      cp       <= cp_next;
      depth    <= depth_next;
      stopped  <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    key      <= key_next;
    scan_pos <= scan_pos_next;
    level    <= level_next;
  end

  // A result is only produced into a free output slot.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    result_load |-> slot_free)
    else $error("result produced while output slot busy");

  // One item at a time: the cycle after a transfer never takes another.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("command accepted while previous one in progress");

  // Tape writes never coincide with the fetch of a new instruction.
  a_tape_interlock: assert property (@(posedge clk) disable iff (rst)
    tape_p.we |-> !accept)
    else $error("tape write overlaps a command transfer");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(STACK_DEPTH))
    else $error("loop stack depth out of range");

endmodule

/* sim/tape_machine_instruction_step_tb.sv */
// ----------------------------------------------------------------------------
// tape_machine_instruction_step_tb: self-checking bench for the tape machine
// Drives load, execute and restart commands over the request channel and
// checks every result against an in-bench machine model or a typed result.
// ----------------------------------------------------------------------------
//
// The bench keeps its own copy of the program store, the data tape, the
// return stack and both pointers. Every accepted command is run through
// that model, and the predicted result is queued. Each result transfer is
// compared field by field against the oldest queued prediction.
//
// Stimulus comes in two parts:
//   1. A short scripted program that walks every instruction, both pointer
//      wraps, a stack underflow, an unknown byte, a matched and an
//      unmatched forward skip, halting, and the commands that are ignored.
//      A few rows (right after reset, load while halted, restart) carry a
//      result typed in by hand; the rest rely on the model.
//   2. Random episodes: a random program with mostly balanced loops is
//      loaded, the machine is restarted, and then stepped with random key
//      bytes. Stray brackets, unknown bytes, undefined commands and loads
//      into the running program are mixed in as noise.
//
// Both sides of the handshake idle at random, with the mode changing from
// one episode to the next.
//
module tape_machine_instruction_step_tb;
  import tmis_pkg::*;

  // Command 3 has no meaning; the block must ignore it.
  localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
  // Any byte outside the instruction set is skipped with a flag.
  localparam logic [BYTE_W-1:0] OP_BOGUS = 8'hFF;

  // A restart sweep or a forward scan can keep both channels quiet while
  // it covers a whole memory, and so can the clearing pass after reset.
  // The limit leaves room for several such passes.
  localparam int QUIET_LIMIT    = 50000;
  localparam int RANDOM_ITEMS   = 420;
  localparam int PRINT_LIMIT    = 100;
  localparam int TAIL_CYCLES    = 8;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    req_t item;
    bit   fixed;
    rsp_t want;
  } script_row_t;

  logic clk;
  logic rst;

  tmis_req_if req_ch ();
  tmis_rsp_if rsp_ch ();

  tape_machine_instruction_step uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Machine model state.
  logic [BYTE_W-1:0] prog_img [PROG_DEPTH];
  logic [BYTE_W-1:0] tape_img [TAPE_DEPTH];
  logic [PROG_AW-1:0] loop_ret [STACK_DEPTH];
  int                 loop_count;
  logic [PROG_AW-1:0] pc_now;
  logic [TAPE_AW-1:0] cell_now;
  logic               halted_now;

  rsp_t        awaited_results [$];
  rsp_t        oldest_result;
  script_row_t opening_rows [$];

  int mismatch_count;
  int useful_items;
  int quiet_cycles;
  int gap_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Machine model
  // ---------------------------------------------------------------------------

  // Scan forward from the '[' at start for its partner. A zero byte stops
  // the scan and the pointer rests on it; running past the last address
  // wraps the pointer to zero.
  function automatic logic [PROG_AW-1:0] find_loop_exit(logic [PROG_AW-1:0] start);
    int pos;
    int level;
    level = 1;
    for (pos = int'(start) + 1; pos < PROG_DEPTH; pos++) begin
      if (prog_img[pos] == OP_HALT) return PROG_AW'(pos);
      if (prog_img[pos] == OP_OPEN) begin
        level++;
      end else if (prog_img[pos] == OP_CLOSE) begin
        level--;
        if (level == 0) return PROG_AW'(pos + 1);
      end
    end
    return '0;
  endfunction

  function automatic rsp_t next_machine_result(req_t r);
    rsp_t               res;
    logic [PROG_AW-1:0] pc;
    logic [PROG_AW-1:0] npc;
    logic [TAPE_AW-1:0] cp;
    logic [BYTE_W-1:0]  op;
    res = '0;
    case (r.cmd)
      CMD_LOAD: begin
        prog_img[r.prog_addr] = r.prog_byte;
      end
      CMD_RESTART: begin
        foreach (tape_img[i]) tape_img[i] = '0;
        loop_count = 0;
        pc_now     = '0;
        cell_now   = '0;
        halted_now = 1'b0;
      end
      CMD_EXEC: begin
        if (!halted_now) begin
          pc  = pc_now;
          cp  = cell_now;
          op  = prog_img[pc];
          npc = pc + 1'b1;
          case (op)
            OP_RIGHT: cell_now = cp + 1'b1;
            OP_LEFT:  cell_now = cp - 1'b1;
            OP_INC:   tape_img[cp] = tape_img[cp] + 1'b1;
            OP_DEC:   tape_img[cp] = tape_img[cp] - 1'b1;
            OP_OUT: begin
              res.out_valid = 1'b1;
              res.out_byte  = tape_img[cp];
            end
            OP_IN: begin
              tape_img[cp] = r.key_byte;
              res.key_used = 1'b1;
            end
            OP_OPEN: begin
              if (tape_img[cp] == '0) begin
                npc = find_loop_exit(pc);
              end else if (loop_count >= STACK_DEPTH) begin
                res.stack_fault = 1'b1;
              end else begin
                loop_ret[loop_count] = pc;
                loop_count++;
              end
            end
            OP_CLOSE: begin
              if (loop_count == 0) begin
                res.stack_fault = 1'b1;
              end else if (tape_img[cp] != '0) begin
                npc = loop_ret[loop_count-1] + 1'b1;
              end else begin
                loop_count--;
              end
            end
            OP_HALT: begin
              halted_now = 1'b1;
              npc        = pc;
            end
            default: res.bad_instruction = 1'b1;
          endcase
          pc_now = npc;
        end
      end
      default: ;
    endcase
    res.halted          = halted_now;
    res.program_counter = pc_now;
    res.tape_position   = cell_now;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic req_t cmd_item(logic [CMD_W-1:0] c, int addr, int pbyte, int key);
    req_t r;
    r.cmd       = c;
    r.prog_addr = addr[ADDR_W-1:0];
    r.prog_byte = pbyte[BYTE_W-1:0];
    r.key_byte  = key[BYTE_W-1:0];
    return r;
  endfunction

  // One scripted row. When fixed is set, the hand-typed result is awaited
  // instead of the model's; the model still runs so its state stays in step.
  function automatic void add_row(logic [CMD_W-1:0] c, int addr, int pbyte, int key,
                                  bit fixed, bit h, int pc, int tp);
    script_row_t r;
    r.item                 = cmd_item(c, addr, pbyte, key);
    r.fixed                = fixed;
    r.want                 = '0;
    r.want.halted          = h;
    r.want.program_counter = pc[ADDR_W-1:0];
    r.want.tape_position   = tp[ADDR_W-1:0];
    opening_rows.push_back(r);
  endfunction

  function automatic void set_idle(idle_mode_e m);
    gap_pct   = (m == IDLE_SEND) ? 67 : (m == IDLE_BOTH) ? 8 : 0;
    stall_pct = (m == IDLE_RECV) ? 67 : (m == IDLE_BOTH) ? 8 : 0;
  endfunction

  // Drive one command, hold it until the transfer, then queue its result.
  // The request only changes at falling edges.
  task automatic send_item(req_t item, bit fixed, rsp_t want);
    rsp_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // Undefined commands and executes while halted only report state.
    if (!(item.cmd == CMD_UNDEF || (item.cmd == CMD_EXEC && halted_now))) useful_items++;
    predicted = next_machine_result(item);
    awaited_results.push_back(fixed ? want : predicted);
  endtask

  // Stop sending and let every queued result come back.
  task automatic wait_all_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_key();
    return ($urandom_range(3) == 0) ? 0 : $urandom_range(255);
  endfunction

  // Load a random program at address 0 followed by a zero byte. Loops are
  // mostly balanced so execution gets past the first few instructions; a
  // few stray brackets and arbitrary bytes go in as noise.
  task automatic load_random_program(int len);
    int                open_loops;
    int                roll;
    logic [BYTE_W-1:0] b;
    open_loops = 0;
    for (int a = 0; a < len; a++) begin
      roll = $urandom_range(99);
      if (open_loops > 0 && len - a <= open_loops) begin
        b = OP_CLOSE;
        open_loops--;
      end else if (roll < 10 && len - a > 2) begin
        b = OP_OPEN;
        open_loops++;
      end else if (roll < 20 && open_loops > 0) begin
        b = OP_CLOSE;
        open_loops--;
      end else if (roll < 22) begin
        b = ($urandom_range(1) == 0) ? OP_OPEN : OP_CLOSE;
      end else if (roll < 25) begin
        b = BYTE_W'($urandom_range(255));
      end else begin
        case ($urandom_range(9))
          0, 1, 2: b = OP_INC;
          3, 4:    b = OP_DEC;
          5:       b = OP_RIGHT;
          6:       b = OP_LEFT;
          7, 8:    b = OP_OUT;
          default: b = OP_IN;
        endcase
      end
      send_item(cmd_item(CMD_LOAD, a, b, $urandom), 1'b0, '0);
    end
    send_item(cmd_item(CMD_LOAD, len, OP_HALT, $urandom), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  // Printing stops after a while so a broken build cannot flood the log;
  // every mismatch is still counted.
  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("result with none awaited", '0, '0);
      end else begin
        oldest_result = awaited_results.pop_front();
        if (rsp_ch.data.out_valid !== oldest_result.out_valid)
          note_mismatch("out_valid", rsp_ch.data.out_valid, oldest_result.out_valid);
        if (rsp_ch.data.out_byte !== oldest_result.out_byte)
          note_mismatch("out_byte", rsp_ch.data.out_byte, oldest_result.out_byte);
        if (rsp_ch.data.key_used !== oldest_result.key_used)
          note_mismatch("key_used", rsp_ch.data.key_used, oldest_result.key_used);
        if (rsp_ch.data.halted !== oldest_result.halted)
          note_mismatch("halted", rsp_ch.data.halted, oldest_result.halted);
        if (rsp_ch.data.bad_instruction !== oldest_result.bad_instruction)
          note_mismatch("bad_instruction", rsp_ch.data.bad_instruction,
                        oldest_result.bad_instruction);
        if (rsp_ch.data.stack_fault !== oldest_result.stack_fault)
          note_mismatch("stack_fault", rsp_ch.data.stack_fault, oldest_result.stack_fault);
        if (rsp_ch.data.program_counter !== oldest_result.program_counter)
          note_mismatch("program_counter", rsp_ch.data.program_counter,
                        oldest_result.program_counter);
        if (rsp_ch.data.tape_position !== oldest_result.tape_position)
          note_mismatch("tape_position", rsp_ch.data.tape_position,
                        oldest_result.tape_position);
      end
    end
  end

  // Watchdog: count cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout at %0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int useful_goal;
    int episode;
    int len;
    int steps;
    int roll;
    req_ch.valid   = 1'b0;
    req_ch.data    = '0;
    rst            = 1'b1;
    mismatch_count = 0;
    useful_items   = 0;
    quiet_cycles   = 0;
    set_idle(IDLE_NONE);

    // The model starts from the reset state of the block.
    foreach (prog_img[i]) prog_img[i] = '0;
    foreach (tape_img[i]) tape_img[i] = '0;
    foreach (loop_ret[i]) loop_ret[i] = '0;
    loop_count = 0;
    pc_now     = '0;
    cell_now   = '0;
    halted_now = 1'b0;

    // Scripted program, laid out as it will sit in memory after the restart:
    //   0 '<'   cell pointer wraps down to the last cell
    //   1 ','   stores key 0xFF
    //   2 '.'   emits 0xFF
    //   3 '+'   cell wraps 0xFF -> 0x00
    //   4 ']'   empty stack: underflow fault
    //   5 0xFF  unknown byte
    //   6 '-'   cell wraps 0x00 -> 0xFF
    //   7 '['   nonzero cell: pushed
    //   8 '>'   cell pointer wraps up to cell 0
    //   9 '['   zero cell: skips to after the ']' at 10
    //  11 '['   zero cell, no partner: rests on the zero byte at 12
    //  12       zero byte: halts
    //           cmd     addr  byte       key    typed h  pc tape
    add_row(CMD_EXEC,    0,    8'h00,     8'h5A, 1, 1, 0, 0); // empty store halts
    add_row(CMD_LOAD,    8191, OP_INC,    8'hFF, 1, 1, 0, 0); // top address, still halted
    add_row(CMD_RESTART, 8191, 8'hFF,     8'hFF, 1, 0, 0, 0);
    add_row(CMD_LOAD,    0,    OP_LEFT,   8'h00, 0, 0, 0, 0);
    add_row(CMD_LOAD,    1,    OP_IN,     8'hFF, 0, 0, 0, 0);
    add_row(CMD_LOAD,    2,    OP_OUT,    8'h00, 0, 0, 0, 0);
    add_row(CMD_LOAD,    3,    OP_INC,    8'h00, 0, 0, 0, 0);
    add_row(CMD_LOAD,    4,    OP_CLOSE,  8'h00, 0, 0, 0, 0);
    add_row(CMD_LOAD,    5,    OP_BOGUS,  8'h00, 0, 0, 0, 0);
    add_row(CMD_LOAD,    6,    OP_DEC,    8'h00, 0, 0, 0, 0);
    add_row(CMD_LOAD,    7,    OP_OPEN,   8'h00, 0, 0, 0, 0);
    add_row(CMD_LOAD,    8,    OP_RIGHT,  8'h00, 0, 0, 0, 0);
    add_row(CMD_LOAD,    9,    OP_OPEN,   8'h00, 0, 0, 0, 0);
    add_row(CMD_LOAD,    10,   OP_CLOSE,  8'h00, 0, 0, 0, 0);
    add_row(CMD_LOAD,    11,   OP_OPEN,   8'h00, 0, 0, 0, 0);
    add_row(CMD_EXEC,    8191, 8'hFF,     8'h00, 0, 0, 0, 0); // '<'
    add_row(CMD_EXEC,    0,    8'h00,     8'hFF, 0, 0, 0, 0); // ','
    add_row(CMD_EXEC,    8191, 8'hFF,     8'h00, 0, 0, 0, 0); // '.'
    add_row(CMD_EXEC,    0,    8'h00,     8'hFF, 0, 0, 0, 0); // '+'
    add_row(CMD_EXEC,    8191, 8'hFF,     8'h00, 0, 0, 0, 0); // ']' underflow
    add_row(CMD_EXEC,    0,    8'h00,     8'hFF, 0, 0, 0, 0); // unknown byte
    add_row(CMD_EXEC,    8191, 8'hFF,     8'h00, 0, 0, 0, 0); // '-'
    add_row(CMD_EXEC,    0,    8'h00,     8'hFF, 0, 0, 0, 0); // '[' push
    add_row(CMD_EXEC,    8191, 8'hFF,     8'h00, 0, 0, 0, 0); // '>'
    add_row(CMD_EXEC,    0,    8'h00,     8'hFF, 0, 0, 0, 0); // '[' matched skip
    add_row(CMD_EXEC,    8191, 8'hFF,     8'h00, 0, 0, 0, 0); // '[' unmatched skip
    add_row(CMD_EXEC,    0,    8'h00,     8'hFF, 0, 0, 0, 0); // zero byte halts
    add_row(CMD_EXEC,    8191, 8'hFF,     8'hFF, 0, 0, 0, 0); // execute while halted
    add_row(CMD_UNDEF,   8191, 8'hFF,     8'hFF, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The scripted part runs with light idling on both sides.
    set_idle(IDLE_BOTH);
    foreach (opening_rows[i])
      send_item(opening_rows[i].item, opening_rows[i].fixed, opening_rows[i].want);

    // Hold off until the machine has caught up before the random part.
    wait_all_results();

    // Random episodes: load, restart, then step until the program halts
    // or the step budget runs out. The idling mode rotates per episode.
    useful_goal = useful_items + RANDOM_ITEMS;
    episode     = 0;
    while (useful_items < useful_goal) begin
      set_idle(idle_mode_e'(episode % 4));
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(3, 30);
      load_random_program(len);
      if ($urandom_range(3) == 0) wait_all_results();
      send_item(cmd_item(CMD_RESTART, $urandom, $urandom, $urandom), 1'b0, '0);
      steps = 3 * len + $urandom_range(40);
      for (int s = 0; s < steps && !halted_now; s++) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          send_item(cmd_item(CMD_UNDEF, $urandom, $urandom, $urandom), 1'b0, '0);
        end else if (roll < 5) begin
          // Rewrite a byte while the program runs, mostly inside it.
          send_item(cmd_item(CMD_LOAD,
                             ($urandom_range(1) == 0) ? $urandom_range(len) : $urandom,
                             $urandom, $urandom), 1'b0, '0);
        end else if (roll < 6) begin
          send_item(cmd_item(CMD_RESTART, $urandom, $urandom, $urandom), 1'b0, '0);
        end else begin
          send_item(cmd_item(CMD_EXEC, $urandom, $urandom, pick_key()), 1'b0, '0);
        end
      end
      if (halted_now && $urandom_range(1) == 0)
        send_item(cmd_item(CMD_EXEC, $urandom, $urandom, $urandom), 1'b0, '0);
      episode++;
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
